/* hdl/i2tac_pkg.sv */
`default_nettype none

package i2tac_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int TEMP_BITS_DEF   = 8;

  // ascii codes
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_TIMES = 8'h2a;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  // operator stack entries
  typedef logic [2:0] opr_t;
  localparam opr_t OPR_ADD  = 3'd0;
  localparam opr_t OPR_SUB  = 3'd1;
  localparam opr_t OPR_MUL  = 3'd2;
  localparam opr_t OPR_DIV  = 3'd3;
  localparam opr_t OPR_LPAR = 3'd4;

  typedef logic [1:0] fault_t;
  localparam fault_t FLT_NONE      = 2'd0;
  localparam fault_t FLT_UNDERFLOW = 2'd1;
  localparam fault_t FLT_UNMATCHED = 2'd2;
  localparam fault_t FLT_OVERFLOW  = 2'd3;

  typedef logic [2:0] cls_t;
  localparam cls_t CLS_OTHER = 3'd0;
  localparam cls_t CLS_OPND  = 3'd1;
  localparam cls_t CLS_LPAR  = 3'd2;
  localparam cls_t CLS_RPAR  = 3'd3;
  localparam cls_t CLS_OPER  = 3'd4;

  typedef struct packed {
    logic [7:0] dest_temp;
    logic       left_is_temp;
    logic [7:0] left_value;
    logic [1:0] op_code;
    logic       right_is_temp;
    logic [7:0] right_value;
    fault_t     fault_code;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic   accept;
    logic   push_opd;
    logic   push_lpar;
    logic   push_op;
    logic   pop_opr;
    logic   apply;
    logic   fault;
    fault_t fault_code;
    logic   clr_opd;
    logic   drain;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    cls_t cls;
    logic eoe;
    logic opr_empty;
    logic opr_full;
    logic opd_full;
    logic opd_lt2;
    logic top_paren;
    logic top_prec_ge;
    logic can_emit;
    logic out_free;
    logic pend_valid;
  } status_t;

  function automatic cls_t char_class(input logic [7:0] ch);
    cls_t c;
    c = CLS_OTHER;
    if ((ch >= CH_D0 && ch <= CH_D9) || (ch >= CH_UA && ch <= CH_UZ) ||
        (ch >= CH_LA && ch <= CH_LZ)) begin
      c = CLS_OPND;
    end else begin
      unique case (ch) inside
        CH_LPAR:                             c = CLS_LPAR;
        CH_RPAR:                             c = CLS_RPAR;
        CH_PLUS, CH_MINUS, CH_TIMES, CH_DIV: c = CLS_OPER;
        default:                             c = CLS_OTHER;
      endcase
    end
    return c;
  endfunction

  function automatic opr_t op_of_char(input logic [7:0] ch);
    opr_t o;
    unique case (ch)
      CH_PLUS:  o = OPR_ADD;
      CH_MINUS: o = OPR_SUB;
      CH_TIMES: o = OPR_MUL;
      CH_DIV:   o = OPR_DIV;
      default:  o = OPR_LPAR;
    endcase
    return o;
  endfunction

  function automatic logic [1:0] prec_of(input opr_t o);
    logic [1:0] p;
    case (o) inside
      OPR_ADD, OPR_SUB: p = 2'd1;
      OPR_MUL, OPR_DIV: p = 2'd2;
      default:          p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* hdl/i2tac_ctrl.sv */
`default_nettype none

module i2tac_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire i2tac_pkg::status_t  st,
  output i2tac_pkg::cmd_t          cmd
);
  import i2tac_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_CLOSE  = 4'd2;
  localparam logic [3:0] S_WCLOSE = 4'd3;
  localparam logic [3:0] S_OPL    = 4'd4;
  localparam logic [3:0] S_WOP    = 4'd5;
  localparam logic [3:0] S_FLUSH  = 4'd6;
  localparam logic [3:0] S_WFLUSH = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        case (st.cls)
          CLS_OPND: begin
            if (!st.opd_full) begin
              cmd.push_opd = 1'b1;
              state_nxt    = S_WFLUSH;
            end else if (st.can_emit) begin
              cmd.fault      = 1'b1;
              cmd.fault_code = FLT_OVERFLOW;
              state_nxt      = S_DONE;
            end
          end
          CLS_LPAR: begin
            if (!st.opr_full) begin
              cmd.push_lpar = 1'b1;
              state_nxt     = S_WFLUSH;
            end else if (st.can_emit) begin
              cmd.fault      = 1'b1;
              cmd.fault_code = FLT_OVERFLOW;
              state_nxt      = S_DONE;
            end
          end
          CLS_RPAR: state_nxt = S_CLOSE;
          CLS_OPER: state_nxt = S_OPL;
          default:  state_nxt = S_FLUSH;
        endcase
      end
      S_CLOSE: begin
        if (st.opr_empty) begin
          if (st.can_emit) begin
            cmd.fault      = 1'b1;
            cmd.fault_code = FLT_UNMATCHED;
            state_nxt      = S_DONE;
          end
        end else if (st.top_paren) begin
          cmd.pop_opr = 1'b1;
          state_nxt   = S_WFLUSH;
        end else if (st.can_emit) begin
          if (st.opd_lt2) begin
            cmd.fault      = 1'b1;
            cmd.fault_code = FLT_UNDERFLOW;
            state_nxt      = S_DONE;
          end else begin
            cmd.apply = 1'b1;
            state_nxt = S_WCLOSE;
          end
        end
      end
      S_WCLOSE: state_nxt = S_CLOSE;
      S_OPL: begin
        if (!st.opr_empty && st.top_prec_ge) begin
          if (st.can_emit) begin
            if (st.opd_lt2) begin
              cmd.fault      = 1'b1;
              cmd.fault_code = FLT_UNDERFLOW;
              state_nxt      = S_DONE;
            end else begin
              cmd.apply = 1'b1;
              state_nxt = S_WOP;
            end
          end
        end else if (!st.opr_full) begin
          cmd.push_op = 1'b1;
          state_nxt   = S_WFLUSH;
        end else if (st.can_emit) begin
          cmd.fault      = 1'b1;
          cmd.fault_code = FLT_OVERFLOW;
          state_nxt      = S_DONE;
        end
      end
      S_WOP: state_nxt = S_OPL;
      S_FLUSH: begin
        if (!st.eoe) begin
          state_nxt = S_DONE;
        end else if (st.opr_empty) begin
          cmd.clr_opd = 1'b1;
          state_nxt   = S_DONE;
        end else if (st.top_paren) begin
          cmd.pop_opr = 1'b1;
          state_nxt   = S_WFLUSH;
        end else if (st.can_emit) begin
          if (st.opd_lt2) begin
            cmd.fault      = 1'b1;
            cmd.fault_code = FLT_UNDERFLOW;
            state_nxt      = S_DONE;
          end else begin
            cmd.apply = 1'b1;
            state_nxt = S_WFLUSH;
          end
        end
      end
      S_WFLUSH: state_nxt = S_FLUSH;
      S_DONE: begin
        if (!st.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.drain = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/i2tac_dp.sv */
`default_nettype none

module i2tac_dp #(
  parameter int STACK_DEPTH = i2tac_pkg::STACK_DEPTH_DEF,
  parameter int TEMP_BITS   = i2tac_pkg::TEMP_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_char,
  input  wire logic               in_eoe,
  input  wire i2tac_pkg::cmd_t    cmd,
  output i2tac_pkg::status_t      st,
  input  wire logic               out_tready,
  output logic                    out_valid,
  output i2tac_pkg::result_t      out_res,
  output logic                    out_last
);
  import i2tac_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0]           chr_r;
  logic                 eoe_r;
  logic [CW-1:0]        opr_cnt_r, opr_cnt_nxt;
  logic [CW-1:0]        opd_cnt_r, opd_cnt_nxt;
  logic [TEMP_BITS-1:0] temp_r;

  opr_t                 opr_mem [STACK_DEPTH];
  logic [8:0]           opd_mem [STACK_DEPTH];
  opr_t                 opr_top_r;
  logic [8:0]           opd_rt_r;
  logic [8:0]           opd_lf_r;

  logic [CW-1:0]        opr_cnt_m1, opd_cnt_m1, opd_cnt_m2;
  logic                 opr_we, opd_we;
  logic [AW-1:0]        opd_wa;
  opr_t                 opr_wd;
  logic [8:0]           opd_wd;
  logic [7:0]           dest8;

  logic                 produce, load_out;
  result_t              new_res;
  logic                 pend_valid_r;
  result_t              pend_res_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  logic                 out_last_r;

  assign opr_cnt_m1 = opr_cnt_r - CW'(1);
  assign opd_cnt_m1 = opd_cnt_r - CW'(1);
  assign opd_cnt_m2 = opd_cnt_r - CW'(2);
  assign dest8      = 8'(temp_r);

  // status toward the controller
  always_comb begin
    st.cls         = char_class(chr_r);
    st.eoe         = eoe_r;
    st.opr_empty   = (opr_cnt_r == '0);
    st.opr_full    = (opr_cnt_r == CW'(STACK_DEPTH));
    st.opd_full    = (opd_cnt_r == CW'(STACK_DEPTH));
    st.opd_lt2     = (opd_cnt_r < CW'(2));
    st.top_paren   = (opr_top_r == OPR_LPAR);
    st.top_prec_ge = (prec_of(opr_top_r) >= prec_of(op_of_char(chr_r)));
    st.out_free    = !out_valid_r || out_tready;
    st.can_emit    = !pend_valid_r || !out_valid_r || out_tready;
    st.pend_valid  = pend_valid_r;
  end

  // stack pointers and temp counter
  always_comb begin
    opr_cnt_nxt = opr_cnt_r;
    opd_cnt_nxt = opd_cnt_r;
    if (cmd.fault) begin
      opr_cnt_nxt = '0;
      opd_cnt_nxt = '0;
    end else begin
      if (cmd.push_lpar || cmd.push_op) opr_cnt_nxt = opr_cnt_r + CW'(1);
      if (cmd.pop_opr || cmd.apply)     opr_cnt_nxt = opr_cnt_m1;
      if (cmd.push_opd)                 opd_cnt_nxt = opd_cnt_r + CW'(1);
      if (cmd.apply)                    opd_cnt_nxt = opd_cnt_m1;
      if (cmd.clr_opd)                  opd_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opr_cnt_r <= '0;
      opd_cnt_r <= '0;
      temp_r    <= '0;
    end else begin
      opr_cnt_r <= opr_cnt_nxt;
      opd_cnt_r <= opd_cnt_nxt;
      if (cmd.apply) temp_r <= temp_r + TEMP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      chr_r <= in_char;
      eoe_r <= in_eoe;
    end
  end

  // stack memories, read data registered from the current pointers
  assign opr_we = cmd.push_lpar || cmd.push_op;
  assign opr_wd = cmd.push_lpar ? OPR_LPAR : op_of_char(chr_r);
  assign opd_we = cmd.push_opd || cmd.apply;
  assign opd_wa = cmd.apply ? opd_cnt_m2[AW-1:0] : opd_cnt_r[AW-1:0];
  assign opd_wd = cmd.apply ? {1'b1, dest8} : {1'b0, chr_r};

  always_ff @(posedge clk) begin
    if (opr_we) opr_mem[opr_cnt_r[AW-1:0]] <= opr_wd;
    opr_top_r <= opr_mem[opr_cnt_m1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (opd_we) opd_mem[opd_wa] <= opd_wd;
    opd_rt_r <= opd_mem[opd_cnt_m1[AW-1:0]];
    opd_lf_r <= opd_mem[opd_cnt_m2[AW-1:0]];
  end

  // result staging: one pending item so the last one of a run can be marked
  assign produce  = cmd.apply || cmd.fault;
  assign load_out = (produce && pend_valid_r) || cmd.drain;

  always_comb begin
    new_res = '0;
    if (cmd.fault) begin
      new_res.fault_code = cmd.fault_code;
    end else begin
      new_res.dest_temp     = dest8;
      new_res.left_is_temp  = opd_lf_r[8];
      new_res.left_value    = opd_lf_r[7:0];
      new_res.op_code       = opr_top_r[1:0];
      new_res.right_is_temp = opd_rt_r[8];
      new_res.right_value   = opd_rt_r[7:0];
      new_res.fault_code    = FLT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (produce) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.drain) begin
        pend_valid_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) pend_res_r <= new_res;
    if (load_out) begin
      out_res_r  <= pend_res_r;
      out_last_r <= cmd.drain;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

  a_opr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    opr_cnt_r <= CW'(STACK_DEPTH))
    else $error("operator pointer beyond depth");

  a_opd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    opd_cnt_r <= CW'(STACK_DEPTH))
    else $error("operand pointer beyond depth");

  a_apply_two: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> (opd_cnt_r >= CW'(2)) && !st.opr_empty && !st.top_paren)
    else $error("apply without two operands or an operator");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_tready))
    else $error("output item overwritten");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain |=> !pend_valid_r && out_valid_r && out_last_r)
    else $error("drain did not deliver the last item");

endmodule

`default_nettype wire

/* hdl/infix_to_three_address_code.sv */
`default_nettype none
// sequencing: an item holds the input from acceptance through decode, the operator pops
//   (instructions emitted, open parens popped) and the flush check; a fault ends it at once;
//   output stalls add to this
// throughput: one item at a time; the next item is taken once the previous run is
//   handed to the output register, which may still wait for out_tready
// reset: rst_n synchronous, active low; clears stack pointers, temp counter and valids

module infix_to_three_address_code #(
  parameter int STACK_DEPTH = i2tac_pkg::STACK_DEPTH_DEF,
  parameter int TEMP_BITS   = i2tac_pkg::TEMP_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input characters
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // end_of_expr
  // three-address instructions and fault items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] dest_temp, [8] left_is_temp,
                                       // [16:9] left_value, [18:17] op_code,
                                       // [19] right_is_temp, [27:20] right_value,
                                       // [29:28] fault_code, [31:30] zero
  output logic             out_tlast   // last_of_run
);
  import i2tac_pkg::*;

  cmd_t    cmd;
  status_t st;
  result_t res;
  logic    res_valid;
  logic    res_last;

  // sequencer: decode, operator pop loops, expression flush
  i2tac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // stacks, temp counter and result staging
  i2tac_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .TEMP_BITS   (TEMP_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_tdata),
    .in_eoe     (in_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_valid  (res_valid),
    .out_res    (res),
    .out_last   (res_last)
  );

  // pack the result, first field lowest
  assign out_tvalid = res_valid;
  assign out_tlast  = res_last;
  assign out_tdata  = {2'b00, res.fault_code, res.right_value, res.right_is_temp,
                       res.op_code, res.left_value, res.left_is_temp, res.dest_temp};

endmodule

`default_nettype wire

/* dv/infix_to_three_address_code_tb.sv */
module infix_to_three_address_code_tb;
  import i2tac_pkg::*;

  localparam int DEPTH         = STACK_DEPTH_DEF;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 16;
  localparam int SETTLE_CYCLES = 60;
  localparam int CALM_CHAIN    = 6;
  localparam int MAX_PRINTS    = 50;

  // a character the block skips, used as filler and as a bare terminator
  localparam logic [7:0] CH_SPACE = 8'h20;

  // one expected instruction or fault item, with the end-of-run marker
  typedef struct {
    result_t    f;
    logic       last;
  } instr_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] char_code
  logic        in_tlast   = 1'b0; // end_of_expr
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [7:0] dest_temp, [8] left_is_temp, [16:9] left_value,
                                  // [18:17] op_code, [19] right_is_temp,
                                  // [27:20] right_value, [29:28] fault_code, [31:30] zero
  logic        out_tlast;         // last_of_run

  // calm turns off random idling on both sides; hold_seq asks the receiver for a long hold
  logic        calm       = 1'b0;
  int          hold_seq   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;

  int          cycle_count = 0;
  int          err_count   = 0;
  int          live_items  = 0;

  // shadow of the block: operator stack, operand stack (temp flag over value), temp counter
  opr_t        opr_stk [DEPTH];
  int          opr_cnt   = 0;
  logic [8:0]  opd_stk [DEPTH];
  int          opd_cnt   = 0;
  logic [7:0]  temp_next = '0;

  result_t     run_q [$];      // instructions of the item being modeled
  instr_t      pending [$];    // instructions still owed by the block, oldest first
  logic [7:0]  expr_q [$];     // characters of the expression being built

  infix_to_three_address_code dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // shunting-yard shadow
  // ---------------------------------------------------------------------------

  // * and / bind tighter than + and -; an open paren never gets popped by an operator
  function automatic int binding_rank(opr_t o);
    case (o)
      OPR_ADD, OPR_SUB: return 1;
      OPR_MUL, OPR_DIV: return 2;
      default:          return 0;
    endcase
  endfunction

  function automatic bit is_name_char(logic [7:0] ch);
    return (ch >= CH_D0 && ch <= CH_D9) || (ch >= CH_UA && ch <= CH_UZ) ||
           (ch >= CH_LA && ch <= CH_LZ);
  endfunction

  function automatic bit is_arith_char(logic [7:0] ch);
    return ch == CH_PLUS || ch == CH_MINUS || ch == CH_TIMES || ch == CH_DIV;
  endfunction

  function automatic opr_t operator_of(logic [7:0] ch);
    case (ch)
      CH_PLUS:  return OPR_ADD;
      CH_MINUS: return OPR_SUB;
      CH_TIMES: return OPR_MUL;
      default:  return OPR_DIV;
    endcase
  endfunction

  // pops right then left, writes a fresh temp back; returns 0 when operands run short
  function automatic bit emit_instr(opr_t o);
    result_t r;
    if (opd_cnt < 2) return 1'b0;
    r               = '0;
    r.right_is_temp = opd_stk[opd_cnt-1][8];
    r.right_value   = opd_stk[opd_cnt-1][7:0];
    r.left_is_temp  = opd_stk[opd_cnt-2][8];
    r.left_value    = opd_stk[opd_cnt-2][7:0];
    r.dest_temp     = temp_next;
    r.op_code       = o[1:0];
    r.fault_code    = FLT_NONE;
    opd_cnt         = opd_cnt - 2;
    opd_stk[opd_cnt] = {1'b1, temp_next};
    opd_cnt         = opd_cnt + 1;
    temp_next       = temp_next + 8'd1;
    run_q.push_back(r);
    return 1'b1;
  endfunction

  // any fault empties both stacks and ends the item with a fault item whose other fields are zero
  function automatic void abort_run(fault_t f);
    result_t r;
    r            = '0;
    r.fault_code = f;
    opr_cnt      = 0;
    opd_cnt      = 0;
    run_q.push_back(r);
  endfunction

  task automatic predict_char(logic [7:0] ch, logic eoe);
    bit     dead;
    bit     closed;
    opr_t   top;
    opr_t   op;
    instr_t e;
    dead = 1'b0;
    run_q.delete();
    if (is_name_char(ch)) begin
      if (opd_cnt >= DEPTH) begin
        abort_run(FLT_OVERFLOW);
        dead = 1'b1;
      end else begin
        opd_stk[opd_cnt] = {1'b0, ch};
        opd_cnt = opd_cnt + 1;
      end
    end else if (ch == CH_LPAR) begin
      if (opr_cnt >= DEPTH) begin
        abort_run(FLT_OVERFLOW);
        dead = 1'b1;
      end else begin
        opr_stk[opr_cnt] = OPR_LPAR;
        opr_cnt = opr_cnt + 1;
      end
    end else if (ch == CH_RPAR) begin
      // unwind to the matching open paren
      closed = 1'b0;
      while (!dead && !closed) begin
        if (opr_cnt == 0) begin
          abort_run(FLT_UNMATCHED);
          dead = 1'b1;
        end else begin
          opr_cnt = opr_cnt - 1;
          top = opr_stk[opr_cnt];
          if (top == OPR_LPAR) begin
            closed = 1'b1;
          end else if (!emit_instr(top)) begin
            abort_run(FLT_UNDERFLOW);
            dead = 1'b1;
          end
        end
      end
    end else if (is_arith_char(ch)) begin
      // left associative: pop everything binding at least as tight
      op = operator_of(ch);
      while (!dead && opr_cnt > 0 && binding_rank(opr_stk[opr_cnt-1]) >= binding_rank(op)) begin
        opr_cnt = opr_cnt - 1;
        top = opr_stk[opr_cnt];
        if (!emit_instr(top)) begin
          abort_run(FLT_UNDERFLOW);
          dead = 1'b1;
        end
      end
      if (!dead) begin
        if (opr_cnt >= DEPTH) begin
          abort_run(FLT_OVERFLOW);
          dead = 1'b1;
        end else begin
          opr_stk[opr_cnt] = op;
          opr_cnt = opr_cnt + 1;
        end
      end
    end
    // expression end: drain the operator stack, leftover open parens vanish
    if (eoe && !dead) begin
      while (!dead && opr_cnt > 0) begin
        opr_cnt = opr_cnt - 1;
        top = opr_stk[opr_cnt];
        if (top != OPR_LPAR && !emit_instr(top)) begin
          abort_run(FLT_UNDERFLOW);
          dead = 1'b1;
        end
      end
      if (!dead) opd_cnt = 0;
    end
    for (int i = 0; i < run_q.size(); i++) begin
      e.f    = run_q[i];
      e.last = (i == run_q.size() - 1);
      pending.push_back(e);
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offers one character, waits for the handshake, then updates the shadow
  task automatic send_char(logic [7:0] ch, logic eoe);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= eoe;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_char(ch, eoe);
    // skipped characters only count when they close an expression
    if (is_name_char(ch) || is_arith_char(ch) || ch == CH_LPAR || ch == CH_RPAR || eoe)
      live_items++;
  endtask

  task automatic send_text(string s, bit eoe_at_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], eoe_at_end && (i == s.len() - 1));
  endtask

  // sends the built expression, now and then with a skipped blank in between
  task automatic send_expr(bit eoe_at_end);
    for (int i = 0; i < expr_q.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_char(CH_SPACE, 1'b0);
      send_char(expr_q[i], eoe_at_end && (i == expr_q.size() - 1));
    end
  endtask

  // sender stops and waits until the block has handed out everything it owes
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0:       return 8'(CH_D0 + $urandom_range(0, 9));
      1:       return 8'(CH_UA + $urandom_range(0, 25));
      default: return 8'(CH_LA + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_TIMES;
      default: return CH_DIV;
    endcase
  endfunction

  // term { op term }, a term being an operand or a parenthesized sub-expression
  task automatic grow_expr(int depth);
    int terms;
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) expr_q.push_back(pick_operator());
      if (depth > 0 && $urandom_range(0, 3) == 0) begin
        expr_q.push_back(CH_LPAR);
        grow_expr(depth - 1);
        expr_q.push_back(CH_RPAR);
      end else begin
        expr_q.push_back(pick_operand());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // random stalls, plus a long hold whenever hold_seq moves
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 10) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic log_mismatch(string what, int got, int exp_v);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
               cycle_count, what, got, exp_v);
  endtask

  // each accepted item is checked field by field against the oldest expectation
  always @(posedge clk) begin
    instr_t want;
    int     got_f [9];
    int     exp_f [9];
    string  names [9];
    names = '{"dest_temp", "left_is_temp", "left_value", "op_code", "right_is_temp",
              "right_value", "fault_code", "last_of_run", "pad bits"};
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        log_mismatch("item with nothing expected", out_tdata, 0);
      end else begin
        want  = pending.pop_front();
        got_f = '{out_tdata[7:0], out_tdata[8], out_tdata[16:9], out_tdata[18:17],
                  out_tdata[19], out_tdata[27:20], out_tdata[29:28], out_tlast,
                  out_tdata[31:30]};
        exp_f = '{want.f.dest_temp, want.f.left_is_temp, want.f.left_value,
                  want.f.op_code, want.f.right_is_temp, want.f.right_value,
                  want.f.fault_code, want.last, 0};
        for (int k = 0; k < 9; k++)
          if (got_f[k] != exp_f[k]) log_mismatch(names[k], got_f[k], exp_f[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // precedence, parens, all four operators, skipped characters and the simple faults
  task automatic test_directed();
    send_text("a+b*c", 1'b1);          // * before +
    send_text("(0-Z)/z", 1'b1);        // parens, - and /, edge operand characters
    send_char(8'h00, 1'b0);            // skipped, lowest code
    send_char(8'hff, 1'b0);            // skipped, highest code
    send_char(CH_SPACE, 1'b1);         // end on empty stacks: nothing comes out
    send_text("a+", 1'b1);             // flush runs short of operands
    send_text("a+b)", 1'b0);           // one instruction, then a close paren with no match
    send_text("(a", 1'b1);             // leftover open paren is dropped quietly
    send_text("9*A", 1'b0);
    send_char(CH_SPACE, 1'b1);         // a skipped character still ends the expression
    wait_drain();
  endtask

  // operand stack, open-paren push and operator push each run into the depth limit
  task automatic test_stack_limits();
    for (int i = 0; i < DEPTH; i++) send_char(8'(CH_LA + i), 1'b0);
    send_char(CH_LZ, 1'b1);
    for (int i = 0; i < DEPTH; i++) send_char(CH_LPAR, 1'b0);
    send_char(CH_LPAR, 1'b1);
    // a stack full of open parens refuses the operator push as well
    for (int i = 0; i < DEPTH; i++) send_char(CH_LPAR, 1'b0);
    send_char(CH_TIMES, 1'b1);
    wait_drain();
  endtask

  // left-associative chain with no idling anywhere on either side
  task automatic test_no_idle();
    calm <= 1'b1;
    send_char(CH_LA, 1'b0);
    for (int i = 0; i < CALM_CHAIN; i++) begin
      send_char(CH_MINUS, 1'b0);
      send_char(pick_operand(), i == CALM_CHAIN - 1);
    end
    wait_drain();
    calm <= 1'b0;
  endtask

  // the receiver holds off for a long stretch while characters keep coming
  task automatic test_backpressure();
    hold_seq <= hold_seq + 1;
    // four instructions from one expression, more than the output side can buffer
    send_text("a*b+c*d-e", 1'b1);
    expr_q.delete();
    grow_expr(2);
    send_expr(1'b1);
    wait_drain();
  endtask

  // mostly well-formed expressions, some broken ones and some raw noise
  task automatic test_random();
    int start;
    int kind;
    int pos;
    start = live_items;
    while (live_items - start < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      expr_q.delete();
      if (kind < 12) begin
        send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        grow_expr($urandom_range(0, 3));
        if (kind < 27) begin
          pos = $urandom_range(0, expr_q.size() - 1);
          case ($urandom_range(0, 3))
            0:       expr_q[pos] = ($urandom_range(0, 1) == 0) ? CH_LPAR : CH_RPAR;
            1:       if (expr_q.size() > 1) void'(expr_q.pop_back());
            2:       expr_q.insert(pos, 8'($urandom_range(0, 255)));
            default: expr_q.insert(pos, pick_operator());
          endcase
          send_expr($urandom_range(0, 3) != 0);
        end else begin
          send_expr(1'b1);
        end
      end
    end
    wait_drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_stack_limits();
    test_no_idle();
    test_backpressure();
    test_random();
    // let any stray item show up before judging
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
